### design/cbid_pkg.sv
`default_nettype none

package cbid_pkg;

    localparam int unsigned POSITION_BITS_DEF = 16;

    localparam logic KIND_ITEM  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [1:0] ERR_TRUNCATED   = 2'd0;
    localparam logic [1:0] ERR_INVALID     = 2'd1;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;

    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BSTR   = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_LIST   = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_PRIM   = 3'd7;

    localparam logic [2:0] TYPE_SIMPLE = 3'd6;

    localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
    localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;
    localparam logic [4:0] AI_INDEFINITE = 5'd31;
    localparam logic [4:0] AI_TWO_BYTE   = 5'd25;

    localparam logic [63:0] SIMPLE_FIRST = 64'd20;
    localparam logic [63:0] SIMPLE_LAST  = 64'd23;

    typedef enum logic [2:0] {
        PH_HEAD    = 3'b001,
        PH_ARG     = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [2:0]  item_type;
        logic [63:0] item_value;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic [1:0]  error_code;
        logic        top_level_done;
    } t_result;

    typedef struct packed {
        logic [1:0]  cont_left;
        logic [1:0]  seq_len;
        logic [20:0] codepoint;
    } t_utf8_state;

endpackage

`default_nettype wire

### design/cbid_utf8.sv
`default_nettype none

module cbid_utf8 (
    input  wire logic [7:0]          i_byte,
    input  wire cbid_pkg::t_utf8_state i_state,
    output cbid_pkg::t_utf8_state    o_state,
    output logic                     o_ok
);
    import cbid_pkg::*;

    logic [20:0] w_cp;
    logic [1:0]  w_cont;

    assign w_cp   = {i_state.codepoint[14:0], i_byte[5:0]};
    assign w_cont = i_state.cont_left - 2'd1;

    always_comb begin
        o_state = i_state;
        o_ok    = 1'b1;
        if (i_state.cont_left == 2'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_ok = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                o_state.seq_len   = 2'd1;
                o_state.cont_left = 2'd1;
                o_state.codepoint = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                o_state.seq_len   = 2'd2;
                o_state.cont_left = 2'd2;
                o_state.codepoint = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                o_state.seq_len   = 2'd3;
                o_state.cont_left = 2'd3;
                o_state.codepoint = {18'd0, i_byte[2:0]};
            end else begin
                o_ok = 1'b0;
            end
        end else if (i_byte[7:6] != 2'b10) begin
            o_ok = 1'b0;
        end else begin
            o_state.codepoint = w_cp;
            o_state.cont_left = w_cont;
            if (w_cont == 2'd0) begin
                // Reject overlong forms, values past the Unicode range and surrogates.
                if (i_state.seq_len == 2'd1 && w_cp < 21'h80) begin
                    o_ok = 1'b0;
                end
                if (i_state.seq_len == 2'd2 && w_cp < 21'h800) begin
                    o_ok = 1'b0;
                end
                if (i_state.seq_len == 2'd3 && w_cp < 21'h10000) begin
                    o_ok = 1'b0;
                end
                if (w_cp > 21'h10ffff) begin
                    o_ok = 1'b0;
                end
                if (w_cp >= 21'hd800 && w_cp <= 21'hdfff) begin
                    o_ok = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

### design/cbid_core.sv
`default_nettype none

module cbid_core #(
    parameter int unsigned POSITION_BITS = cbid_pkg::POSITION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire cbid_pkg::t_in_item       i_item,
    input  wire logic [POSITION_BITS-1:0] i_msg_len,
    output logic                          o_res_valid,
    output cbid_pkg::t_result             o_res
);
    import cbid_pkg::*;

    localparam int unsigned PB = POSITION_BITS;
    // Pending count can grow by nearly the remaining length at every head.
    localparam int unsigned PW = 2 * PB + 1;

    logic [PB-1:0] r_pos, n_pos;
    t_phase        r_phase, n_phase;
    logic [3:0]    r_argl, n_argl;
    logic [2:0]    r_mt, n_mt;
    logic [63:0]   r_acc, n_acc;
    logic [PB-1:0] r_pbl, n_pbl;
    logic [PB-1:0] r_pstart, n_pstart;
    t_utf8_state   r_utf, n_utf;
    logic [PW-1:0] r_pend, n_pend;
    logic          r_err, n_err;

    logic          w_start;
    logic [PB-1:0] w_pos;
    logic [PW-1:0] w_pend;
    logic          w_err;
    t_phase        w_phase;
    logic [3:0]    w_argl;
    t_utf8_state   w_utf;
    logic          w_active;
    logic [PB:0]   w_pos_after;
    logic [PB-1:0] w_rem;
    logic [7:0]    w_b;
    logic [2:0]    w_hmt;
    logic [4:0]    w_ai;
    logic [3:0]    w_nbytes;
    logic [63:0]   w_acc_shift;
    t_utf8_state   w_utf_next;
    logic          w_utf_ok;
    logic          w_fin;
    logic [63:0]   w_fin_v;
    logic [2:0]    w_fin_mt;
    logic          w_close;
    logic [PW-1:0] w_added;
    logic [PW-1:0] w_pend_sum;

    cbid_utf8 u_utf8 (
        .i_byte  (w_b),
        .i_state (w_utf),
        .o_state (w_utf_next),
        .o_ok    (w_utf_ok)
    );

    assign w_start     = i_item.start_of_message;
    assign w_pos       = w_start ? '0 : r_pos;
    assign w_pend      = w_start ? PW'(1) : r_pend;
    assign w_err       = w_start ? 1'b0 : r_err;
    assign w_phase     = w_start ? PH_HEAD : r_phase;
    assign w_argl      = w_start ? 4'd0 : r_argl;
    assign w_active    = !w_err && (w_pos < i_msg_len);
    assign w_pos_after = {1'b0, w_pos} + (PB+1)'(1);
    assign w_rem       = PB'({1'b0, i_msg_len} - w_pos_after);
    assign w_b         = i_item.data_byte;
    assign w_hmt       = w_b[7:5];
    assign w_ai        = w_b[4:0];
    assign w_nbytes    = 4'(4'd1 << w_ai[1:0]);
    assign w_acc_shift = {r_acc[55:0], w_b};

    always_comb begin
        w_utf           = r_utf;
        w_utf.cont_left = w_start ? 2'd0 : r_utf.cont_left;
    end

    always_comb begin
        n_pos    = w_pos;
        n_phase  = w_phase;
        n_argl   = w_argl;
        n_mt     = r_mt;
        n_acc    = r_acc;
        n_pbl    = r_pbl;
        n_pstart = r_pstart;
        n_utf    = w_utf;
        n_pend   = w_pend;
        n_err    = w_err;
        o_res_valid = 1'b0;
        o_res       = '0;
        w_fin    = 1'b0;
        w_fin_v  = '0;
        w_fin_mt = r_mt;
        w_close  = 1'b0;
        w_added  = '0;
        w_pend_sum = '0;

        if (w_active) begin
            n_pos = PB'(w_pos_after);
            unique case (w_phase)
                PH_ARG: begin
                    n_acc  = w_acc_shift;
                    n_argl = w_argl - 4'd1;
                    if (w_argl == 4'd1) begin
                        w_fin   = 1'b1;
                        w_fin_v = w_acc_shift;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_mt == MT_TEXT && !w_utf_ok) begin
                        o_res_valid = 1'b1;
                        o_res.result_kind = KIND_ERROR;
                        o_res.error_code  = ERR_INVALID;
                    end else begin
                        if (r_mt == MT_TEXT) begin
                            n_utf = w_utf_next;
                        end
                        n_pbl = r_pbl - PB'(1);
                        if (r_pbl == PB'(1)) begin
                            n_phase     = PH_HEAD;
                            o_res_valid = 1'b1;
                            if (r_mt == MT_TEXT && w_utf_next.cont_left != 2'd0) begin
                                o_res.result_kind = KIND_ERROR;
                                o_res.error_code  = ERR_INVALID;
                            end else begin
                                w_close = 1'b1;
                                o_res.item_type      = r_mt;
                                o_res.item_value     = r_acc;
                                o_res.payload_offset = 16'(r_pstart);
                                o_res.payload_length = r_acc[15:0];
                            end
                        end
                    end
                end
                default: begin
                    n_mt     = w_hmt;
                    w_fin_mt = w_hmt;
                    if (w_ai < AI_ONE_BYTE) begin
                        if (w_hmt == MT_TAG) begin
                            o_res_valid = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_UNSUPPORTED;
                        end else begin
                            w_fin   = 1'b1;
                            w_fin_v = 64'(w_ai);
                        end
                    end else if (w_ai <= AI_EIGHT_BYTE) begin
                        if (w_rem < PB'(w_nbytes)) begin
                            o_res_valid = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_TRUNCATED;
                        end else if (w_hmt == MT_TAG
                                     || (w_hmt == MT_PRIM && w_ai >= AI_TWO_BYTE)) begin
                            o_res_valid = 1'b1;
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_UNSUPPORTED;
                        end else begin
                            n_argl  = w_nbytes;
                            n_acc   = '0;
                            n_phase = PH_ARG;
                        end
                    end else if (w_ai == AI_INDEFINITE) begin
                        o_res_valid = 1'b1;
                        o_res.result_kind = KIND_ERROR;
                        o_res.error_code  = ERR_UNSUPPORTED;
                    end else begin
                        o_res_valid = 1'b1;
                        o_res.result_kind = KIND_ERROR;
                        o_res.error_code  = ERR_INVALID;
                    end
                end
            endcase

            if (w_fin) begin
                n_phase     = PH_HEAD;
                o_res_valid = 1'b1;
                case (w_fin_mt)
                    MT_UINT, MT_NEGINT: begin
                        w_close = 1'b1;
                        o_res.item_type  = w_fin_mt;
                        o_res.item_value = w_fin_v;
                    end
                    MT_BSTR, MT_TEXT: begin
                        if (w_fin_v > 64'(w_rem)) begin
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_TRUNCATED;
                        end else if (w_fin_v == 64'd0) begin
                            w_close = 1'b1;
                            o_res.item_type      = w_fin_mt;
                            o_res.payload_offset = 16'(w_pos_after);
                        end else begin
                            o_res_valid = 1'b0;
                            n_acc    = w_fin_v;
                            n_pstart = PB'(w_pos_after);
                            n_pbl    = w_fin_v[PB-1:0];
                            n_utf    = '0;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                    MT_LIST: begin
                        if (w_fin_v > 64'(w_rem)) begin
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_TRUNCATED;
                        end else begin
                            w_close = 1'b1;
                            w_added = PW'(w_fin_v[PB-1:0]);
                            o_res.item_type  = MT_LIST;
                            o_res.item_value = w_fin_v;
                        end
                    end
                    MT_MAP: begin
                        if (w_fin_v > 64'(w_rem >> 1)) begin
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_TRUNCATED;
                        end else begin
                            w_close = 1'b1;
                            w_added = PW'({w_fin_v[PB-1:0], 1'b0});
                            o_res.item_type  = MT_MAP;
                            o_res.item_value = w_fin_v;
                        end
                    end
                    MT_PRIM: begin
                        if (w_fin_v < SIMPLE_FIRST || w_fin_v > SIMPLE_LAST) begin
                            o_res.result_kind = KIND_ERROR;
                            o_res.error_code  = ERR_UNSUPPORTED;
                        end else begin
                            w_close = 1'b1;
                            o_res.item_type  = TYPE_SIMPLE;
                            o_res.item_value = w_fin_v;
                        end
                    end
                    default: begin
                        o_res.result_kind = KIND_ERROR;
                        o_res.error_code  = ERR_UNSUPPORTED;
                    end
                endcase
            end

            if (w_close) begin
                w_pend_sum = w_pend + w_added - PW'(1);
                if (w_pend_sum == '0) begin
                    n_pend = PW'(1);
                    o_res.top_level_done = 1'b1;
                end else begin
                    n_pend = w_pend_sum;
                end
            end

            if (o_res_valid && o_res.result_kind == KIND_ERROR) begin
                n_err   = 1'b1;
                n_phase = PH_HEAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_HEAD;
            r_argl  <= 4'd0;
            r_pend  <= PW'(1);
            r_err   <= 1'b0;
            r_utf   <= '0;
        end else if (i_en) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_argl  <= n_argl;
            r_pend  <= n_pend;
            r_err   <= n_err;
            r_utf   <= n_utf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mt     <= n_mt;
            r_acc    <= n_acc;
            r_pbl    <= n_pbl;
            r_pstart <= n_pstart;
        end
    end

    a_pend_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != '0)
        else $error("pending count reached zero without reload");

    a_quiet_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_err && !w_start) |-> !o_res_valid)
        else $error("result produced after an error without a new message");

    a_arg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ARG) |-> (r_argl != 4'd0))
        else $error("argument phase with no bytes left");

    a_error_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.result_kind == KIND_ERROR) |-> !o_res.top_level_done)
        else $error("error result flagged as closing a top-level item");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pbl != '0))
        else $error("payload phase with no bytes left");

endmodule

`default_nettype wire

### design/cbor_item_head_decoder.sv
`default_nettype none

// CBOR item-head decoder. Message bytes arrive one per beat; write the message
// length before the first byte and mark that byte with start_of_message. The
// block takes one byte every cycle while the output is not stalled: each byte
// passes from an input register through the parser state update into a result
// register, so an item's result is presented from that register, and the output
// register lets the next byte enter while a result waits to be taken. A result is
// produced for the byte that completes an item (the last payload byte of a
// string), or for the first fault, after which bytes are dropped until the
// next start of message. Bytes at or past the message length give no result.
module cbor_item_head_decoder #(
    parameter int unsigned POSITION_BITS = cbid_pkg::POSITION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire cbid_pkg::t_in_item i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cbid_pkg::t_result       o_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data
);
    import cbid_pkg::*;

    localparam int unsigned LW = (POSITION_BITS < 16) ? POSITION_BITS : 16;

    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_result                  r_out;
    logic [POSITION_BITS-1:0] r_msg_len;
    logic                     w_adv;
    logic                     w_res_valid;
    t_result                  w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    cbid_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_item      (r_in),
        .i_msg_len   (r_msg_len),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_msg_len   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_msg_len <= POSITION_BITS'(i_cfg_data[LW-1:0]);
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_cbor_item_head_decoder.sv
module tb_cbor_item_head_decoder;
    import cbid_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_result     o_out_item;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    cbor_item_head_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_in_item   byte_queue[$];
    t_result    expected_results[$];
    logic [7:0] msg_bytes[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         in_took = 1'b0;
    bit         quiet = 1'b0;
    bit         hold_done = 1'b0;
    int         send_gap_odds = 4;
    int         recv_gap_odds = 6;
    int         rx_hold_cycles = 0;
    int         tx_gap = 0;
    int         rx_gap = 0;

    // Mirror of the decoder state.
    logic [15:0] msg_length = '0;
    logic [15:0] read_pos = '0;
    t_phase      phase = PH_HEAD;
    int unsigned arg_left = 0;
    logic [2:0]  held_mt = '0;
    logic [63:0] value_acc = '0;
    logic [63:0] payload_left = '0;
    logic [15:0] payload_base = '0;
    int unsigned cont_left = 0;
    int unsigned seq_len = 0;
    logic [20:0] codepoint = '0;
    logic [63:0] items_pending = 64'd1;
    bit          err_latched = 1'b0;

    function automatic void push_item(logic [2:0] ty, logic [63:0] v, logic [15:0] off,
                                      logic [15:0] len, bit done);
        t_result r;
        r = '0;
        r.result_kind = KIND_ITEM;
        r.item_type = ty;
        r.item_value = v;
        r.payload_offset = off;
        r.payload_length = len;
        r.top_level_done = done;
        expected_results.push_back(r);
    endfunction

    function automatic void push_error(logic [1:0] code);
        t_result r;
        r = '0;
        r.result_kind = KIND_ERROR;
        r.error_code = code;
        expected_results.push_back(r);
        err_latched = 1'b1;
        phase = PH_HEAD;
    endfunction

    function automatic bit close_item(logic [63:0] added);
        items_pending = items_pending + added - 64'd1;
        if (items_pending == 0) begin
            items_pending = 64'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void finish_head(logic [63:0] v, logic [16:0] pos_after);
        logic [63:0] rem;
        rem = 64'(msg_length) - 64'(pos_after);
        phase = PH_HEAD;
        case (held_mt)
            MT_UINT, MT_NEGINT: begin
                push_item(held_mt, v, '0, '0, close_item(0));
            end
            MT_BSTR, MT_TEXT: begin
                if (v > rem) begin
                    push_error(ERR_TRUNCATED);
                end else if (v == 0) begin
                    push_item(held_mt, '0, pos_after[15:0], '0, close_item(0));
                end else begin
                    value_acc = v;
                    payload_base = pos_after[15:0];
                    payload_left = v;
                    cont_left = 0;
                    seq_len = 0;
                    codepoint = '0;
                    phase = PH_PAYLOAD;
                end
            end
            MT_LIST: begin
                if (v > rem) push_error(ERR_TRUNCATED);
                else push_item(MT_LIST, v, '0, '0, close_item(v));
            end
            MT_MAP: begin
                if (v > rem / 2) push_error(ERR_TRUNCATED);
                else push_item(MT_MAP, v, '0, '0, close_item(v * 2));
            end
            MT_PRIM: begin
                if (v < SIMPLE_FIRST || v > SIMPLE_LAST) push_error(ERR_UNSUPPORTED);
                else push_item(TYPE_SIMPLE, v, '0, '0, close_item(0));
            end
            default: push_error(ERR_UNSUPPORTED);
        endcase
    endfunction

    function automatic bit text_byte_ok(logic [7:0] c);
        if (cont_left == 0) begin
            if (c < 8'h80) return 1'b1;
            if ((c & 8'he0) == 8'hc0) begin
                seq_len = 1;
                codepoint = 21'(c & 8'h1f);
            end else if ((c & 8'hf0) == 8'he0) begin
                seq_len = 2;
                codepoint = 21'(c & 8'h0f);
            end else if ((c & 8'hf8) == 8'hf0) begin
                seq_len = 3;
                codepoint = 21'(c & 8'h07);
            end else begin
                return 1'b0;
            end
            cont_left = seq_len;
            return 1'b1;
        end
        if ((c & 8'hc0) != 8'h80) return 1'b0;
        codepoint = {codepoint[14:0], c[5:0]};
        cont_left--;
        if (cont_left != 0) return 1'b1;
        if (seq_len == 1 && codepoint < 21'h80) return 1'b0;
        if (seq_len == 2 && codepoint < 21'h800) return 1'b0;
        if (seq_len == 3 && codepoint < 21'h10000) return 1'b0;
        if (codepoint > 21'h10ffff) return 1'b0;
        if (codepoint >= 21'hd800 && codepoint <= 21'hdfff) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void decode_byte(t_in_item it);
        logic [7:0]  b;
        logic [16:0] pos;
        logic [2:0]  mt;
        logic [4:0]  ai;
        int unsigned nbytes;
        b = it.data_byte;
        if (it.start_of_message) begin
            read_pos = '0;
            items_pending = 64'd1;
            err_latched = 1'b0;
            phase = PH_HEAD;
            arg_left = 0;
            cont_left = 0;
        end
        if (err_latched || read_pos >= msg_length) return;
        pos = 17'(read_pos);
        read_pos = read_pos + 16'd1;
        if (phase == PH_ARG) begin
            value_acc = {value_acc[55:0], b};
            arg_left--;
            if (arg_left == 0) finish_head(value_acc, pos + 17'd1);
            return;
        end
        if (phase == PH_PAYLOAD) begin
            if (held_mt == MT_TEXT && !text_byte_ok(b)) begin
                push_error(ERR_INVALID);
                return;
            end
            payload_left--;
            if (payload_left != 0) return;
            phase = PH_HEAD;
            if (held_mt == MT_TEXT && cont_left != 0) begin
                push_error(ERR_INVALID);
                return;
            end
            push_item(held_mt, value_acc, payload_base, value_acc[15:0], close_item(0));
            return;
        end
        mt = b[7:5];
        ai = b[4:0];
        held_mt = mt;
        if (ai < AI_ONE_BYTE) begin
            if (mt == MT_TAG) push_error(ERR_UNSUPPORTED);
            else finish_head(64'(ai), pos + 17'd1);
        end else if (ai <= AI_EIGHT_BYTE) begin
            nbytes = 1 << (ai - AI_ONE_BYTE);
            if (32'(msg_length) - 32'(pos + 17'd1) < nbytes) begin
                push_error(ERR_TRUNCATED);
            end else if (mt == MT_TAG || (mt == MT_PRIM && ai >= AI_TWO_BYTE)) begin
                push_error(ERR_UNSUPPORTED);
            end else begin
                arg_left = nbytes;
                value_acc = '0;
                phase = PH_ARG;
            end
        end else if (ai == AI_INDEFINITE) begin
            push_error(ERR_UNSUPPORTED);
        end else begin
            push_error(ERR_INVALID);
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Input acceptance feeds the predictor; output beats are checked in order.
    always @(posedge i_clk) begin
        t_result w;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_cbor_item_head_decoder failed");
            $finish;
        end else begin
            in_took = i_rst_n && i_in_valid && !o_in_stall;
            if (in_took) decode_byte(i_in_item);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report("unexpected beat, kind", 64'(o_out_item.result_kind), 0);
                end else begin
                    w = expected_results.pop_front();
                    if (o_out_item.result_kind !== w.result_kind)
                        report("result_kind", 64'(o_out_item.result_kind), 64'(w.result_kind));
                    if (o_out_item.item_type !== w.item_type)
                        report("item_type", 64'(o_out_item.item_type), 64'(w.item_type));
                    if (o_out_item.item_value !== w.item_value)
                        report("item_value", o_out_item.item_value, w.item_value);
                    if (o_out_item.payload_offset !== w.payload_offset)
                        report("payload_offset", 64'(o_out_item.payload_offset),
                               64'(w.payload_offset));
                    if (o_out_item.payload_length !== w.payload_length)
                        report("payload_length", 64'(o_out_item.payload_length),
                               64'(w.payload_length));
                    if (o_out_item.error_code !== w.error_code)
                        report("error_code", 64'(o_out_item.error_code), 64'(w.error_code));
                    if (o_out_item.top_level_done !== w.top_level_done)
                        report("top_level_done", 64'(o_out_item.top_level_done),
                               64'(w.top_level_done));
                end
            end
        end
    end

    // Sender: holds a beat until it is taken, with random gaps between beats.
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !in_took)) begin
        end else if (tx_gap > 0) begin
            tx_gap--;
            i_in_valid <= 1'b0;
        end else if (!quiet && send_gap_odds != 0 && $urandom_range(send_gap_odds - 1) == 0) begin
            tx_gap = $urandom_range(4);
            i_in_valid <= 1'b0;
        end else if (byte_queue.size() != 0) begin
            i_in_item <= byte_queue.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_stall <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && recv_gap_odds != 0 && $urandom_range(recv_gap_odds - 1) == 0) begin
            rx_gap = $urandom_range(4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic wait_idle();
        do @(posedge i_clk);
        while (byte_queue.size() != 0 || i_in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_message(int len);
        t_in_item it;
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= 16'(len);
        msg_length = 16'(len);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        foreach (msg_bytes[k]) begin
            it.data_byte = msg_bytes[k];
            it.start_of_message = (k == 0);
            byte_queue.push_back(it);
        end
        msg_bytes.delete();
    endtask

    task automatic put_head(logic [2:0] mt, logic [63:0] v);
        int n;
        if (v < 24 && $urandom_range(3) != 0) begin
            msg_bytes.push_back({mt, 5'(v)});
            return;
        end
        n = (v < 256) ? 0 : (v < 65536) ? 1 : (v < 64'h1_0000_0000) ? 2 : 3;
        if (n < 3 && mt != MT_PRIM && $urandom_range(3) == 0) n = n + 1;
        if (mt == MT_PRIM) n = 0;
        msg_bytes.push_back({mt, 5'(AI_ONE_BYTE + n)});
        for (int k = (1 << n) - 1; k >= 0; k--) msg_bytes.push_back(v[8 * k +: 8]);
    endtask

    task automatic put_text();
        logic [7:0] t[$];
        int         chars;
        int unsigned cp;
        chars = $urandom_range(4);
        repeat (chars) begin
            case ($urandom_range(3))
                0: t.push_back(8'($urandom_range(8'h7f)));
                1: begin
                    cp = $urandom_range(12'h7ff, 8'h80);
                    t.push_back(8'hc0 | 8'(cp >> 6));
                    t.push_back(8'h80 | 8'(cp & 6'h3f));
                end
                2: begin
                    cp = $urandom_range(16'hffff, 16'h800);
                    if (cp >= 16'hd800 && cp <= 16'hdfff) cp = cp - 16'h1000;
                    t.push_back(8'he0 | 8'(cp >> 12));
                    t.push_back(8'h80 | 8'((cp >> 6) & 6'h3f));
                    t.push_back(8'h80 | 8'(cp & 6'h3f));
                end
                default: begin
                    cp = $urandom_range(21'h10ffff, 21'h10000);
                    t.push_back(8'hf0 | 8'(cp >> 18));
                    t.push_back(8'h80 | 8'((cp >> 12) & 6'h3f));
                    t.push_back(8'h80 | 8'((cp >> 6) & 6'h3f));
                    t.push_back(8'h80 | 8'(cp & 6'h3f));
                end
            endcase
        end
        put_head(MT_TEXT, 64'(t.size()));
        foreach (t[k]) msg_bytes.push_back(t[k]);
    endtask

    task automatic put_item(int depth);
        int          n;
        logic [63:0] v;
        case ($urandom_range(depth < 3 ? 7 : 4))
            0, 1: begin
                case ($urandom_range(3))
                    0: v = 64'($urandom_range(23));
                    1: v = 64'($urandom_range(65535));
                    2: v = 64'($urandom);
                    default: v = {$urandom, $urandom};
                endcase
                put_head($urandom_range(1) ? MT_NEGINT : MT_UINT, v);
            end
            2: begin
                n = $urandom_range(6);
                put_head(MT_BSTR, 64'(n));
                repeat (n) msg_bytes.push_back(8'($urandom));
            end
            3: put_text();
            4: put_head(MT_PRIM, 64'($urandom_range(SIMPLE_LAST, SIMPLE_FIRST)));
            5: begin
                n = $urandom_range(3);
                put_head(MT_LIST, 64'(n));
                repeat (n) put_item(depth + 1);
            end
            default: begin
                n = $urandom_range(2);
                put_head(MT_MAP, 64'(n));
                repeat (2 * n) put_item(depth + 1);
            end
        endcase
    endtask

    task automatic directed(input logic [7:0] b[$], input int len);
        msg_bytes = b;
        send_message(len < 0 ? b.size() : len);
    endtask

    initial begin
        int sent;
        int len;
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Well-formed heads at the field extremes, then each fault on its own.
        directed('{8'h00, 8'h17, 8'h18, 8'hff, 8'h20, 8'h37, 8'h1b, 8'hff, 8'hff, 8'hff,
                   8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hf4, 8'hf7, 8'h40, 8'h60, 8'h80,
                   8'ha0, 8'h82, 8'h01, 8'h61, 8'h41}, -1);
        directed('{8'h1c, 8'h00, 8'h00}, -1);
        directed('{8'h1f}, -1);
        directed('{8'hc0}, -1);
        directed('{8'hd8, 8'h01}, -1);
        directed('{8'hf9, 8'h00, 8'h00}, -1);
        directed('{8'hf8, 8'h13}, -1);
        directed('{8'h19, 8'h00}, -1);
        directed('{8'h62, 8'h41}, -1);
        directed('{8'ha1, 8'h00}, -1);
        directed('{8'h81}, -1);
        directed('{8'h61, 8'hc3}, -1);
        directed('{8'h62, 8'hc0, 8'h80}, -1);
        directed('{8'h63, 8'hed, 8'ha0, 8'h80}, -1);
        directed('{8'h64, 8'hf4, 8'h90, 8'h80, 8'h80}, -1);
        directed('{8'h61, 8'hff}, -1);
        directed('{8'h62, 8'hc3, 8'h41}, -1);
        directed('{8'h00, 8'h00, 8'h01}, 1);
        directed('{8'h00, 8'h01}, 0);
        directed('{8'h5a, 8'hff, 8'hff, 8'hff, 8'hff}, 65535);
        directed('{8'h59, 8'h00, 8'h02, 8'hab, 8'hcd, 8'h1b}, 65535);

        sent = 0;
        while (sent < 400) begin
            quiet = (sent > 340);
            send_gap_odds = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 2);
            recv_gap_odds = $urandom_range(3) == 0 ? 0 : $urandom_range(8, 2);
            if ($urandom_range(9) == 0) begin
                // Noise, with stray starts in the middle.
                n = $urandom_range(12, 1);
                repeat (n) msg_bytes.push_back(8'($urandom));
                len = $urandom_range(n + 2);
                send_message(len);
                for (int k = byte_queue.size() - n + 1; k < byte_queue.size(); k++)
                    if ($urandom_range(7) == 0) byte_queue[k].start_of_message = 1'b1;
            end else begin
                repeat ($urandom_range(4, 1)) put_item(0);
                n = msg_bytes.size();
                len = n;
                case ($urandom_range(7))
                    0: msg_bytes[$urandom_range(n - 1)] = 8'($urandom);
                    1: len = n - $urandom_range(n < 3 ? n : 3);
                    2: len = n + $urandom_range(3, 1);
                    default: ;
                endcase
                send_message(len);
                // Hold the receiver off while this message streams in.
                if (!hold_done && sent > 100) begin
                    rx_hold_cycles = 80;
                    hold_done = 1'b1;
                end
            end
            sent += n;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("tb_cbor_item_head_decoder passed");
        end else begin
            $display("tb_cbor_item_head_decoder failed");
        end
        $finish;
    end

endmodule

### cbor_item_head_decoder.f
design/cbid_pkg.sv
design/cbid_utf8.sv
design/cbid_core.sv
design/cbor_item_head_decoder.sv
tb/sv/tb_cbor_item_head_decoder.sv
